// ===== hw/rtl/twb_pkg.sv =====
// twb_pkg: shared types and constants for the tiled watermark blend block
// no dependencies; used by tiled_watermark_blend and twb_blend under hw/rtl
`timescale 1ns / 1ps

package twb_pkg;

    localparam int DEF_TILE_SIDE       = 64;
    localparam int DEF_MAX_IMAGE_WIDTH = 4096;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_WIDTH    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_HEIGHT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_MODE    = 3'd4;

    localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [6:0]  RST_TILE_WIDTH    = 7'd64;
    localparam logic [6:0]  RST_TILE_HEIGHT   = 7'd64;
    localparam logic [7:0]  RST_KEY_THRESHOLD = 8'h33;
    localparam logic        RST_BLEND_MODE    = 1'b0;

    localparam logic        MODE_APPLY  = 1'b0;
    localparam logic        MODE_REMOVE = 1'b1;

    localparam logic        ACTION_LOAD  = 1'b0;
    localparam logic        ACTION_IMAGE = 1'b1;

    localparam logic [9:0]  CHANNEL_MAX = 10'd255;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] key_threshold;
        logic       blend_mode;
    } blend_cfg_t;

endpackage

// ===== hw/rtl/tiled_watermark_blend.sv =====
// tiled_watermark_blend: top level with config registers, tile counters and pipeline
// depends on twb_pkg, twb_ram, twb_blend
`timescale 1ns / 1ps

// Takes one beat per clock while s_tready is high, load or image, with no bubbles between
// them. Load beats write the watermark tile store (TILE_SIDE x TILE_SIDE pixels, one
// single-port ram) in raster order; image beats read it at the wrapping tile position and
// give one result beat through the ram read stage and then the output register. The next
// beat is accepted while a result waits; input stalls only when both the ram read stage
// and the output register are full. Tile entries never loaded read as undefined, so the
// store needs no clearing after reset. The user must write configuration through the cfg
// port only while the block is idle; the block itself does not enforce this.

module tiled_watermark_blend #(
    parameter int TILE_SIDE       = twb_pkg::DEF_TILE_SIDE,
    parameter int MAX_IMAGE_WIDTH = twb_pkg::DEF_MAX_IMAGE_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // red, green, blue
    input  logic [1:0]                       s_tuser,   // action, first
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // out_red, out_green, out_blue
    output logic                             m_tuser,   // marked
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [twb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [twb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int XW    = (TILE_SIDE > 1) ? $clog2(TILE_SIDE) : 1;
    localparam int TCW   = ((XW > 7) ? XW : 7) + 1;
    localparam int DEPTH = TILE_SIDE * TILE_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
    localparam int ICW   = ((CW > 13) ? CW : 13) + 1;

    // configuration registers
    logic [12:0] image_width_reg;
    logic [6:0]  tile_width_reg;
    logic [6:0]  tile_height_reg;
    logic [7:0]  key_threshold_reg;
    logic        blend_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= twb_pkg::RST_IMAGE_WIDTH;
            tile_width_reg    <= twb_pkg::RST_TILE_WIDTH;
            tile_height_reg   <= twb_pkg::RST_TILE_HEIGHT;
            key_threshold_reg <= twb_pkg::RST_KEY_THRESHOLD;
            blend_mode_reg    <= twb_pkg::RST_BLEND_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                twb_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                twb_pkg::CFG_TILE_WIDTH:    tile_width_reg    <= cfg_data[6:0];
                twb_pkg::CFG_TILE_HEIGHT:   tile_height_reg   <= cfg_data[6:0];
                twb_pkg::CFG_KEY_THRESHOLD: key_threshold_reg <= cfg_data[7:0];
                twb_pkg::CFG_BLEND_MODE:    blend_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [TCW-1:0] tw, th, tw_raw, th_raw;
    logic [ICW-1:0] iw, iw_raw;

    assign tw_raw = TCW'(tile_width_reg);
    assign th_raw = TCW'(tile_height_reg);
    assign iw_raw = ICW'(image_width_reg);

    always_comb
    begin
        if (tw_raw == '0)
            tw = TCW'(1);
        else if (tw_raw > TCW'(TILE_SIDE))
            tw = TCW'(TILE_SIDE);
        else
            tw = tw_raw;
        if (th_raw == '0)
            th = TCW'(1);
        else if (th_raw > TCW'(TILE_SIDE))
            th = TCW'(TILE_SIDE);
        else
            th = th_raw;
        if (iw_raw == '0)
            iw = ICW'(1);
        else if (iw_raw > ICW'(MAX_IMAGE_WIDTH))
            iw = ICW'(MAX_IMAGE_WIDTH);
        else
            iw = iw_raw;
    end

    // handshake and pipeline control
    logic s_accept, s_action, s_first, s1_move;
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    twb_pkg::pixel_t s_pix, s1_pix_reg, ram_rdata, blend_res, out_pix_reg;
    logic blend_marked, out_marked_reg;

    assign s_pix    = twb_pkg::pixel_t'(s_tdata);
    assign s_action = s_tuser[0];
    assign s_first  = s_tuser[1];
    assign s1_move  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_accept = s_tvalid && s_tready;

    // counters
    logic [XW-1:0] load_x_reg, load_x_next, load_y_reg, load_y_next;
    logic [XW-1:0] tile_x_reg, tile_x_next, tile_y_reg, tile_y_next;
    logic [CW-1:0] image_col_reg, image_col_next;
    logic [XW-1:0] cur_lx, cur_ly, cur_tx, cur_ty;
    logic [CW-1:0] cur_col;
    logic [TCW-1:0] lx_inc, ly_inc, tx_inc, ty_inc;
    logic [ICW-1:0] col_inc;
    logic [AW-1:0] ram_addr;
    logic          ram_we;

    always_comb
    begin
        cur_lx  = s_first ? '0 : load_x_reg;
        cur_ly  = s_first ? '0 : load_y_reg;
        cur_tx  = s_first ? '0 : tile_x_reg;
        cur_ty  = s_first ? '0 : tile_y_reg;
        cur_col = s_first ? '0 : image_col_reg;
        lx_inc  = TCW'(cur_lx) + TCW'(1);
        ly_inc  = TCW'(cur_ly) + TCW'(1);
        tx_inc  = TCW'(cur_tx) + TCW'(1);
        ty_inc  = TCW'(cur_ty) + TCW'(1);
        col_inc = ICW'(cur_col) + ICW'(1);

        load_x_next    = load_x_reg;
        load_y_next    = load_y_reg;
        tile_x_next    = tile_x_reg;
        tile_y_next    = tile_y_reg;
        image_col_next = image_col_reg;

        if (s_accept && s_action == twb_pkg::ACTION_LOAD)
        begin
            if (lx_inc >= tw)
            begin
                load_x_next = '0;
                load_y_next = (ly_inc >= th) ? '0 : ly_inc[XW-1:0];
            end
            else
            begin
                load_x_next = lx_inc[XW-1:0];
                load_y_next = cur_ly;
            end
        end
        else if (s_accept)
        begin
            if (col_inc >= iw)
            begin
                image_col_next = '0;
                tile_x_next    = '0;
                tile_y_next    = (ty_inc >= th) ? '0 : ty_inc[XW-1:0];
            end
            else
            begin
                image_col_next = col_inc[CW-1:0];
                tile_x_next    = (tx_inc >= tw) ? '0 : tx_inc[XW-1:0];
                tile_y_next    = cur_ty;
            end
        end

        if (s_action == twb_pkg::ACTION_LOAD)
            ram_addr = AW'(cur_ly * TILE_SIDE + cur_lx);
        else
            ram_addr = AW'(cur_ty * TILE_SIDE + cur_tx);
        ram_we = (s_action == twb_pkg::ACTION_LOAD);

        s1_valid_next  = (s_accept && s_action == twb_pkg::ACTION_IMAGE)
                      || (s1_valid_reg && !s1_move);
        out_valid_next = (s1_valid_reg && s1_move) || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_x_reg    <= '0;
            load_y_reg    <= '0;
            tile_x_reg    <= '0;
            tile_y_reg    <= '0;
            image_col_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_x_reg    <= load_x_next;
            load_y_reg    <= load_y_next;
            tile_x_reg    <= tile_x_next;
            tile_y_reg    <= tile_y_next;
            image_col_reg <= image_col_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept && s_action == twb_pkg::ACTION_IMAGE)
        begin
            s1_pix_reg <= s_pix;
        end
        if (s1_valid_reg && s1_move)
        begin
            out_pix_reg    <= blend_res;
            out_marked_reg <= blend_marked;
        end
    end

    twb_ram #(
        .WIDTH ($bits(twb_pkg::pixel_t)),
        .DEPTH (DEPTH)
    ) u_tile_store (
        .clk   (clk),
        .en    (s_accept),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_pix),
        .rdata (ram_rdata)
    );

    twb_pkg::blend_cfg_t blend_cfg;

    assign blend_cfg.key_threshold = key_threshold_reg;
    assign blend_cfg.blend_mode    = blend_mode_reg;

    twb_blend u_blend (
        .cfg    (blend_cfg),
        .img    (s1_pix_reg),
        .wm     (ram_rdata),
        .res    (blend_res),
        .marked (blend_marked)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tuser  = out_marked_reg;

    // checks
    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> $stable(ram_rdata))
        else $error("tile store read data changed while the read stage was stalled");

    a_image_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_action == twb_pkg::ACTION_IMAGE) |=> s1_valid_reg)
        else $error("accepted image beat did not enter the read stage");

    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        (image_col_reg == '0) |-> (tile_x_reg == '0))
        else $error("tile column not restarted at the start of an image row");

endmodule

// ===== hw/rtl/twb_ram.sv =====
// twb_ram: generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module twb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/twb_blend.sv =====
// twb_blend: keyed watermark test and per-channel average or removal
// depends on twb_pkg
`timescale 1ns / 1ps

module twb_blend (
    input  twb_pkg::blend_cfg_t cfg,
    input  twb_pkg::pixel_t     img,
    input  twb_pkg::pixel_t     wm,
    output twb_pkg::pixel_t     res,
    output logic                marked
);

    function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] w,
                                                 input logic mode);
        logic [8:0] sum;
        logic [9:0] diff;
        logic [7:0] r;
        sum  = {1'b0, a} + {1'b0, w};
        diff = {1'b0, a, 1'b0} - {2'b00, w};
        if (mode == twb_pkg::MODE_APPLY)
        begin
            r = sum[8:1];
        end
        else if (diff[9])
        begin
            r = 8'd0;
        end
        else if (diff > twb_pkg::CHANNEL_MAX)
        begin
            r = twb_pkg::CHANNEL_MAX[7:0];
        end
        else
        begin
            r = diff[7:0];
        end
        return r;
    endfunction

    logic key_hit;

    assign key_hit = (wm.red < cfg.key_threshold) || (wm.green < cfg.key_threshold)
                  || (wm.blue < cfg.key_threshold);

    always_comb
    begin
        if (key_hit)
        begin
            res.red   = blend_channel(img.red, wm.red, cfg.blend_mode);
            res.green = blend_channel(img.green, wm.green, cfg.blend_mode);
            res.blue  = blend_channel(img.blue, wm.blue, cfg.blend_mode);
        end
        else
        begin
            res = img;
        end
        marked = key_hit;
    end

endmodule
